// ===== sv/rhlp_pkg.sv =====
// ----------------------------------------------------------------------------
// rhlp_pkg
// Types, codes and character helpers shared by the header line parser.
// ----------------------------------------------------------------------------
package rhlp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_SOURCE_BYTES = 4096;
  localparam int unsigned DEF_ID_LIMIT         = 64;

  // Fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STATUS_W   = 4;
  localparam int unsigned ID_START_W = 12;
  localparam int unsigned ID_LEN_W   = 6;
  localparam int unsigned KW_IDX_W   = 4;

  // Length counters saturate at 2^13-1
  localparam int unsigned LEN_W = 13;
  localparam logic [LEN_W-1:0]    LEN_MAX    = '1;
  localparam logic [ID_LEN_W-1:0] ID_LEN_MAX = '1;

  localparam logic [KW_IDX_W-1:0] KW_LEN = 4'd9;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_KEYWORD,
    PH_COLON,
    PH_AFTER_COLON,
    PH_ID,
    PH_DONE
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 4'd0,
    ST_NO_HASH    = 4'd1,
    ST_NO_KEYWORD = 4'd2,
    ST_NO_COLON   = 4'd3,
    ST_ID_MISSING = 4'd4,
    ST_NO_NEWLINE = 4'd5,
    ST_EMPTY      = 4'd6,
    ST_TOO_LONG   = 4'd7,
    ST_ILLEGAL    = 4'd8
  } status_e;

  // Parser state apart from the position counters
  typedef struct packed {
    phase_e              phase;
    logic [KW_IDX_W-1:0] kw_idx;
    logic [LEN_W-1:0]    committed_len;
    logic [LEN_W-1:0]    pending_blanks;
    logic                bad_char;
    status_e             latched_status;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:          PH_LEAD,
    kw_idx:         '0,
    committed_len:  '0,
    pending_blanks: '0,
    bad_char:       1'b0,
    latched_status: ST_OK
  };

  // Verdict for one text, minus the id offset
  typedef struct packed {
    status_e             status;
    logic [ID_LEN_W-1:0] id_length;
  } verdict_t;

  function automatic logic [BYTE_W-1:0] kw_char(input logic [KW_IDX_W-1:0] idx);
    case (idx)
      4'd0:    kw_char = 8'h63; // c
      4'd1:    kw_char = 8'h6F; // o
      4'd2:    kw_char = 8'h6E; // n
      4'd3:    kw_char = 8'h74; // t
      4'd4:    kw_char = 8'h61; // a
      4'd5:    kw_char = 8'h69; // i
      4'd6:    kw_char = 8'h6E; // n
      4'd7:    kw_char = 8'h65; // e
      4'd8:    kw_char = 8'h72; // r
      default: kw_char = CH_NUL;
    endcase
  endfunction

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    is_blank = (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    is_space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_newline(input logic [BYTE_W-1:0] c);
    is_newline = (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    is_alnum = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic status_e end_status(input phase_e ph, input status_e latched);
    case (ph)
      PH_LEAD:        end_status = ST_NO_HASH;
      PH_KEYWORD:     end_status = ST_NO_KEYWORD;
      PH_COLON:       end_status = ST_NO_COLON;
      PH_AFTER_COLON: end_status = ST_ID_MISSING;
      PH_ID:          end_status = ST_NO_NEWLINE;
      default:        end_status = latched;
    endcase
  endfunction

endpackage

// ===== sv/rhlp_step.sv =====
// ----------------------------------------------------------------------------
// rhlp_step
// Next-state and verdict logic for one text byte.
// ----------------------------------------------------------------------------
module rhlp_step #(
  parameter int unsigned MAX_SOURCE_BYTES = rhlp_pkg::DEF_MAX_SOURCE_BYTES,
  parameter int unsigned ID_LIMIT         = rhlp_pkg::DEF_ID_LIMIT,
  localparam int unsigned POS_W           = $clog2(MAX_SOURCE_BYTES)
) (
  input  rhlp_pkg::parse_state_t   state_i,
  input  logic [POS_W-1:0]         pos_i,
  input  logic [POS_W-1:0]         first_off_i,
  input  logic [rhlp_pkg::BYTE_W-1:0] byte_i,
  input  logic                     last_i,
  output rhlp_pkg::parse_state_t   state_o,
  output logic [POS_W-1:0]         pos_o,
  output logic [POS_W-1:0]         first_off_o,
  output rhlp_pkg::verdict_t       verdict_o,
  output logic [POS_W-1:0]         verdict_off_o
);
  import rhlp_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_SOURCE_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(ID_LIMIT);

  parse_state_t     st;
  logic [POS_W-1:0] first_off;
  logic             take_id;
  logic [LEN_W:0]   sum_wide;
  logic [LEN_W-1:0] sum_sat;
  logic             punct;
  status_e          final_status;

  always_comb begin
    st        = state_i;
    first_off = first_off_i;
    take_id   = 1'b0;
    sum_wide  = '0;
    sum_sat   = '0;
    punct     = 1'b0;

    if (st.phase != PH_DONE) begin
      if (byte_i == CH_NUL) begin
        // string end: settle on what is missing so far
        st.latched_status = end_status(st.phase, st.latched_status);
        st.phase          = PH_DONE;
      end else begin
        case (st.phase)
          PH_LEAD: begin
            if (byte_i == CH_HASH) begin
              st.phase  = PH_KEYWORD;
              st.kw_idx = '0;
            end else if (!is_space(byte_i)) begin
              st.latched_status = ST_NO_HASH;
              st.phase          = PH_DONE;
            end
          end
          PH_KEYWORD: begin
            if (!(st.kw_idx == '0 && is_blank(byte_i))) begin
              if (st.kw_idx < KW_LEN && byte_i == kw_char(st.kw_idx)) begin
                st.kw_idx = st.kw_idx + 1'b1;
                if (st.kw_idx >= KW_LEN) st.phase = PH_COLON;
              end else begin
                st.latched_status = ST_NO_KEYWORD;
                st.phase          = PH_DONE;
              end
            end
          end
          PH_COLON: begin
            if (byte_i == CH_COLON) begin
              st.phase = PH_AFTER_COLON;
            end else if (!is_blank(byte_i)) begin
              st.latched_status = ST_NO_COLON;
              st.phase          = PH_DONE;
            end
          end
          PH_AFTER_COLON: begin
            if (!is_blank(byte_i)) begin
              first_off = pos_i;
              if (is_newline(byte_i)) begin
                st.latched_status = ST_EMPTY;
                st.phase          = PH_DONE;
              end else begin
                st.phase          = PH_ID;
                st.committed_len  = '0;
                st.pending_blanks = '0;
                st.bad_char       = 1'b0;
                take_id           = 1'b1;
              end
            end
          end
          PH_ID: begin
            take_id = 1'b1;
          end
          default: begin
          end
        endcase

        if (take_id) begin
          if (is_newline(byte_i)) begin
            if (st.committed_len == '0)            st.latched_status = ST_EMPTY;
            else if (st.committed_len >= LEN_LIMIT) st.latched_status = ST_TOO_LONG;
            else if (st.bad_char)                  st.latched_status = ST_ILLEGAL;
            else                                   st.latched_status = ST_OK;
            st.phase = PH_DONE;
          end else if (is_blank(byte_i)) begin
            if (st.pending_blanks != LEN_MAX) st.pending_blanks = st.pending_blanks + 1'b1;
          end else begin
            punct = (byte_i == CH_UNDER) || (byte_i == CH_DOT) || (byte_i == CH_DASH);
            if (st.pending_blanks != '0) st.bad_char = 1'b1;
            if (!is_alnum(byte_i) && (!punct || st.committed_len == '0)) st.bad_char = 1'b1;
            // held blanks become part of the id, then the byte itself
            sum_wide = {1'b0, st.committed_len} + {1'b0, st.pending_blanks};
            sum_sat  = sum_wide[LEN_W] ? LEN_MAX : sum_wide[LEN_W-1:0];
            st.committed_len  = (sum_sat == LEN_MAX) ? LEN_MAX : sum_sat + 1'b1;
            st.pending_blanks = '0;
          end
        end
      end
    end
  end

  always_comb begin
    final_status         = end_status(st.phase, st.latched_status);
    verdict_o.status     = final_status;
    verdict_o.id_length  = '0;
    if (final_status == ST_OK || final_status == ST_ILLEGAL) begin
      verdict_o.id_length = (st.committed_len > LEN_W'(ID_LEN_MAX)) ? ID_LEN_MAX
                            : st.committed_len[ID_LEN_W-1:0];
    end else if (final_status == ST_TOO_LONG) begin
      verdict_o.id_length = ID_LEN_MAX;
    end
  end

  // id offset including this byte, before the clear on the last byte
  assign verdict_off_o = first_off;

  // Last byte: verdict goes out and the parser starts over
  assign state_o     = last_i ? PARSE_RESET : st;
  assign first_off_o = last_i ? '0 : first_off;
  assign pos_o       = last_i ? '0 : ((pos_i != POS_LAST) ? pos_i + 1'b1 : pos_i);

endmodule

// ===== sv/runtime_header_line_parser_core.sv =====
// ----------------------------------------------------------------------------
// runtime_header_line_parser_core
// Byte-stream parser for a "#container: <id>" header line.
// ----------------------------------------------------------------------------
// Feed the source text one byte per word on the slave stream, tlast on the
// final byte. Unless the master side stalls, the block accepts one word every
// clock cycle with no gaps; each word passes an input register, one step of
// combinational parse logic and, on the final byte only, lands in the output
// register, from which the verdict word (status, id start offset, trimmed id
// length) goes out. Nothing comes out for other bytes. A stalled
// master side holds the verdict; the slave side keeps flowing until the
// input register is also blocked. After each verdict the parser is back in
// its reset state, ready for the next text. A zero byte ends the text early:
// the verdict is fixed there and later bytes up to tlast are ignored.
// Byte offsets saturate at MAX_SOURCE_BYTES-1; ids of ID_LIMIT bytes or more
// report too long.
module runtime_header_line_parser_core #(
  parameter int unsigned MAX_SOURCE_BYTES = rhlp_pkg::DEF_MAX_SOURCE_BYTES,
  parameter int unsigned ID_LIMIT         = rhlp_pkg::DEF_ID_LIMIT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: text bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  // master side: verdicts
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [3:0] status, [15:4] id_start,
                                      // [21:16] id_length, [23:22] zero
);
  import rhlp_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_SOURCE_BYTES);

  // input register
  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;

  // parser state
  parse_state_t      state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  first_off_q, first_off_d;

  // output register
  logic              out_valid_q, out_valid_d;
  verdict_t          out_verdict_q;
  logic [POS_W-1:0]  out_off_q;

  verdict_t          verdict;
  logic [POS_W-1:0]  verdict_off;
  logic              advance;
  logic              in_take;
  logic [ID_START_W+POS_W-1:0] off_ext;

  // a parsed byte moves on when the output slot is free or drains this cycle
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  rhlp_step #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES),
    .ID_LIMIT        (ID_LIMIT)
  ) u_step (
    .state_i      (state_q),
    .pos_i        (pos_q),
    .first_off_i  (first_off_q),
    .byte_i       (in_byte_q),
    .last_i       (in_last_q),
    .state_o      (state_d),
    .pos_o        (pos_d),
    .first_off_o  (first_off_d),
    .verdict_o    (verdict),
    .verdict_off_o(verdict_off)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)      in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_last_q) out_valid_d = 1'b1;
    else if (m_axis_tready)   out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= PARSE_RESET;
      pos_q       <= '0;
      first_off_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q     <= state_d;
        pos_q       <= pos_d;
        first_off_q <= first_off_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_verdict_q <= verdict;
      // offset of the id as it stands after this final byte
      out_off_q     <= verdict_off;
    end
  end

  assign off_ext       = {{ID_START_W{1'b0}}, out_off_q};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_verdict_q.id_length, off_ext[ID_START_W-1:0],
                          out_verdict_q.status};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ok_has_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_verdict_q.status == ST_OK) |-> (out_verdict_q.id_length != '0))
    else $error("ok verdict with empty id");

  a_too_long_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_verdict_q.status == ST_TOO_LONG)
      |-> (out_verdict_q.id_length == ID_LEN_MAX))
    else $error("too-long verdict without saturated length");

  a_fail_zero_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_verdict_q.status != ST_OK && out_verdict_q.status != ST_ILLEGAL
      && out_verdict_q.status != ST_TOO_LONG) |-> (out_verdict_q.id_length == '0))
    else $error("failure verdict carries an id length");

  a_reset_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (state_q.phase == PH_LEAD && pos_q == '0))
    else $error("parser not cleared after final byte");

  a_empty_in_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input register empty but not ready");

endmodule

// ===== bench/header_verdict_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// header_verdict_checker
// Watches both streams of the header line parser. Every accepted text byte
// runs through its own copy of the parse state. Each predicted verdict is
// compared field by field with the next verdict word the block gives out.
// ----------------------------------------------------------------------------
module header_verdict_checker #(
  parameter int unsigned MAX_SOURCE_BYTES = rhlp_pkg::DEF_MAX_SOURCE_BYTES,
  parameter int unsigned ID_LIMIT         = rhlp_pkg::DEF_ID_LIMIT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          errors_o,
  output int          pending_o
);
  import rhlp_pkg::*;

  // first keyword character in the top byte
  localparam logic [71:0] KEYWORD = "container";

  typedef struct packed {
    status_e                  status;
    logic [ID_START_W-1:0]    id_start;
    logic [ID_LEN_W-1:0]      id_length;
  } verdict_word_t;

  verdict_word_t pending_verdicts[$];
  int mismatch_count = 0;

  phase_e                parse_phase = PH_LEAD;
  logic [KW_IDX_W-1:0]   kw_pos      = '0;
  logic [ID_START_W-1:0] byte_pos    = '0;
  logic [ID_START_W-1:0] id_offset   = '0;
  logic [LEN_W-1:0]      id_len_run  = '0;
  logic [LEN_W-1:0]      blank_run   = '0;
  logic                  id_bad      = 1'b0;
  status_e               held_status = ST_OK;

  function automatic logic blank_byte(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic logic white_byte(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic line_end(input logic [7:0] c);
    return c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic alnum_byte(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] a, input int b);
    int s;
    s = int'(a) + b;
    return (s > int'(LEN_MAX)) ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  // status if the text stopped right here
  function automatic status_e open_status();
    case (parse_phase)
      PH_LEAD:        return ST_NO_HASH;
      PH_KEYWORD:     return ST_NO_KEYWORD;
      PH_COLON:       return ST_NO_COLON;
      PH_AFTER_COLON: return ST_ID_MISSING;
      PH_ID:          return ST_NO_NEWLINE;
      default:        return held_status;
    endcase
  endfunction

  task automatic settle(input status_e st);
    held_status = st;
    parse_phase = PH_DONE;
  endtask

  task automatic clear_state();
    parse_phase = PH_LEAD;
    kw_pos      = '0;
    byte_pos    = '0;
    id_offset   = '0;
    id_len_run  = '0;
    blank_run   = '0;
    id_bad      = 1'b0;
    held_status = ST_OK;
  endtask

  task automatic id_byte(input logic [7:0] c);
    if (line_end(c)) begin
      if (id_len_run == 0) settle(ST_EMPTY);
      else if (id_len_run >= ID_LIMIT) settle(ST_TOO_LONG);
      else if (id_bad) settle(ST_ILLEGAL);
      else settle(ST_OK);
    end else if (blank_byte(c)) begin
      blank_run = len_add(blank_run, 1);
    end else begin
      // blanks followed by more id text are not trailing
      if (blank_run != 0) id_bad = 1'b1;
      if (!alnum_byte(c) &&
          (!(c == CH_UNDER || c == CH_DASH || c == CH_DOT) || id_len_run == 0))
        id_bad = 1'b1;
      id_len_run = len_add(len_add(id_len_run, int'(blank_run)), 1);
      blank_run  = '0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic last);
    verdict_word_t v;
    if (parse_phase != PH_DONE) begin
      if (c == CH_NUL) begin
        settle(open_status());
      end else begin
        case (parse_phase)
          PH_LEAD: begin
            if (c == CH_HASH) begin
              parse_phase = PH_KEYWORD;
              kw_pos      = '0;
            end else if (!white_byte(c)) begin
              settle(ST_NO_HASH);
            end
          end
          PH_KEYWORD: begin
            if (!(kw_pos == 0 && blank_byte(c))) begin
              if (kw_pos < KW_LEN && c == KEYWORD[8*(8-kw_pos) +: 8]) begin
                kw_pos = kw_pos + 1'b1;
                if (kw_pos >= KW_LEN) parse_phase = PH_COLON;
              end else begin
                settle(ST_NO_KEYWORD);
              end
            end
          end
          PH_COLON: begin
            if (c == CH_COLON) parse_phase = PH_AFTER_COLON;
            else if (!blank_byte(c)) settle(ST_NO_COLON);
          end
          PH_AFTER_COLON: begin
            if (!blank_byte(c)) begin
              id_offset = byte_pos;
              if (line_end(c)) begin
                settle(ST_EMPTY);
              end else begin
                parse_phase = PH_ID;
                id_len_run  = '0;
                blank_run   = '0;
                id_bad      = 1'b0;
                id_byte(c);
              end
            end
          end
          PH_ID: begin
            id_byte(c);
          end
          default: ;
        endcase
      end
    end
    if (byte_pos < MAX_SOURCE_BYTES - 1) byte_pos = byte_pos + 1'b1;
    if (last) begin
      v.status   = open_status();
      v.id_start = id_offset;
      if (v.status == ST_OK || v.status == ST_ILLEGAL)
        v.id_length = (id_len_run > 63) ? ID_LEN_MAX : id_len_run[ID_LEN_W-1:0];
      else if (v.status == ST_TOO_LONG)
        v.id_length = ID_LEN_MAX;
      else
        v.id_length = '0;
      pending_verdicts.push_back(v);
      clear_state();
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_word_t want;
    if (!rst_ni) begin
      clear_state();
      pending_verdicts.delete();
      mismatch_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_verdicts.size() == 0) begin
          $error("verdict word %h with nothing expected", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = pending_verdicts.pop_front();
          check_field("status", want.status, m_axis_tdata[3:0]);
          check_field("id_start", want.id_start, m_axis_tdata[15:4]);
          check_field("id_length", want.id_length, m_axis_tdata[21:16]);
          check_field("pad", 0, m_axis_tdata[23:22]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      errors_o  <= mismatch_count;
      pending_o <= pending_verdicts.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the header line parser: a directed set of texts covering
// every status and the corner cases, then random texts, mostly well-formed
// headers with random ids and some broken or pure noise. Both streams idle
// at random; the checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb;
  import rhlp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no word moving
  localparam int unsigned TAIL_CYCLES    = 10;   // wait after the last verdict before the summary
  localparam int unsigned RANDOM_BYTES   = 620;
  localparam int unsigned RANDOM_TEXTS   = 24;   // keep going until at least this many texts are sent

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [23:0] m_axis_tdata;

  int   errors;
  int   pending;
  logic gaps_on = 1'b1;      // random idling on both sides
  logic [7:0] text_q[$];     // text being built, sent as one run
  int   bytes_sent  = 0;
  int   idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  runtime_header_line_parser_core DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  header_verdict_checker checker_i (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .errors_o  (errors),
    .pending_o (pending)
  );

  // receiver stalls at random, with odds of 19 in 100, while gaps are on
  always @(posedge clk_i) begin
    m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 19);
  end

  // watchdog: nothing accepted on either side for too long ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --- text building ---------------------------------------------------------

  task automatic add_byte(input logic [7:0] b);
    text_q.push_back(b);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_run(input logic [7:0] b, input int n);
    repeat (n) text_q.push_back(b);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'h30 + r[7:0];
    else if (r < 36) return 8'h41 + r[7:0] - 8'd10;
    else return 8'h61 + r[7:0] - 8'd36;
  endfunction

  task automatic add_id(input int n);
    repeat (n) text_q.push_back(rand_alnum());
  endtask

  // space, tab or 0x0A..0x0D
  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + r[7:0];
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  // id content: mostly legal, with some punctuation, blanks and junk
  function automatic logic [7:0] rand_id_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return rand_alnum();
    if (r < 88) begin
      case ($urandom_range(0, 2))
        0:       return CH_UNDER;
        1:       return CH_DASH;
        default: return CH_DOT;
      endcase
    end
    if (r < 93) return rand_blank();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic build_random_text();
    int n;
    int cut;
    if ($urandom_range(0, 99) >= 80) begin
      // pure noise
      n = $urandom_range(1, 8);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) add_byte(rand_space());
      add_byte(($urandom_range(0, 19) != 0) ? CH_HASH : 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) add_byte(rand_blank());
      add_str("container");
      if ($urandom_range(0, 14) == 0)
        text_q[text_q.size() - 1 - $urandom_range(0, 8)] = 8'($urandom_range(0, 255));
      repeat ($urandom_range(0, 2)) add_byte(rand_blank());
      add_byte(($urandom_range(0, 14) != 0) ? CH_COLON : 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) add_byte(rand_blank());
      // short ids mostly, now and then one near the length limit
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 12);
      repeat (n) add_byte(rand_id_byte());
      repeat ($urandom_range(0, 2)) add_byte(rand_blank());
      n = $urandom_range(0, 9);
      if (n < 5) add_byte(CH_LF);
      else if (n < 9) add_byte(CH_CR);
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
      // text cut short
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
      // zero byte somewhere
      if ($urandom_range(0, 19) == 0) text_q[$urandom_range(0, text_q.size() - 1)] = CH_NUL;
    end
  endtask

  // --- stream driving --------------------------------------------------------

  // Drive one word and hold it until taken. tready is sampled at the falling
  // edge so the decision never races the rising edge.
  task automatic send_word(input logic [7:0] b, input logic l);
    logic rdy;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 19) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    bytes_sent++;
  endtask

  // whole text, tlast on the final byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_word(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // sender holds off until every predicted verdict has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int rand_start;
    int rand_texts;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed texts ---
    add_str("#container:abc\n");                               send_text();
    // every kind of leading white space, blanks around each token
    add_byte(CH_SPACE);
    for (int b = 9; b <= 13; b++) add_byte(8'(b));
    add_str("#\t container \t:\t my_id-1.x \t\n");             send_text();
    add_str("hello\n");                                        send_text();
    add_str(" \t");                                            send_text();
    add_str("#cont");                                          send_text();
    add_str("#container \t");                                  send_text();
    add_str("#container: ");                                   send_text();
    add_str("#container: ab");                                 send_text();
    // newline right after the colon blanks
    add_str("#container:\n");                                  send_text();
    add_str("#container: \t\r");                               send_text();
    add_str("#c ontainer:x\n");                                send_text();
    add_str("#container x\n");                                 send_text();
    // id length around the limit; too long beats an illegal first character
    add_str("#container:"); add_id(63); add_str("\n");         send_text();
    add_str("#container:"); add_id(64); add_str("\n");         send_text();
    add_str("#container:_"); add_id(63); add_str("\n");        send_text();
    add_str("#container:"); add_id(62); add_str("  \t\n");     send_text();
    // inner blank, punctuation first, high byte, other junk
    add_str("#container:a b\n");                               send_text();
    add_str("#container:_abc\n");                              send_text();
    add_str("#container:a"); add_byte(8'h80); add_str("\n");   send_text();
    add_byte(8'hFF); add_str("#container:a@b\r");              send_text();
    add_str("#container:a.b-c_d\nrest");                       send_text();
    // zero byte ends the text early, or is ignored once settled
    add_str("#cont"); add_byte(CH_NUL); add_str("ainer:x\n");  send_text();
    add_str("#container: "); add_byte(CH_NUL); add_str("x\n"); send_text();
    add_str("#container:ab\n"); add_byte(CH_NUL);              send_text();
    add_byte(CH_NUL);                                          send_text();
    // text ends on the first id byte
    add_str("#container: "); add_run(8'h61, 1);                send_text();
    wait_drained();

    // --- random texts ---
    rand_start = bytes_sent;
    rand_texts = 0;
    while ((bytes_sent - rand_start) < RANDOM_BYTES || rand_texts < RANDOM_TEXTS) begin
      // one long stretch with no idling on either side
      if ((bytes_sent - rand_start) >= 300 && (bytes_sent - rand_start) < 700)
        gaps_on <= 1'b0;
      else
        gaps_on <= 1'b1;
      build_random_text();
      send_text();
      rand_texts++;
      if (rand_texts == 12) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
